@@ hw/rtl/adll_pkg.sv @@
// ---------------------------------------------------------------------------
// adll_pkg
// types and constants shared by the array doubly linked list
// ---------------------------------------------------------------------------
package adll_pkg;
	localparam int unsigned CAPACITY = 16;
	localparam int unsigned DATA_WIDTH = 32;
	localparam int unsigned SW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		K_PUSH_HEAD = 4'd0, K_PUSH_TAIL = 4'd1, K_INS_AFTER = 4'd2,
		K_INS_BEFORE = 4'd3, K_DELETE = 4'd4, K_READ_POS = 4'd5,
		K_HEAD = 4'd6, K_TAIL = 4'd7, K_NEXT = 4'd8, K_PREV = 4'd9,
		K_CLEAR = 4'd10
	} kind_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_WALK, S_PNX, S_SPV, S_DONE
	} state_t;

	// one write port request for the slot memory
	typedef struct packed {
		logic nx_we;
		logic pv_we;
		logic val_we;
		logic [SW-1:0] addr;
		logic [SW-1:0] nx;
		logic [SW-1:0] pv;
		logic [DATA_WIDTH-1:0] val;
	} wr_t;
endpackage

@@ hw/rtl/adll_mem.sv @@
// ---------------------------------------------------------------------------
// adll_mem
// slot memory: next link, previous link and value, one read and one write
// ---------------------------------------------------------------------------
module adll_mem
	import adll_pkg::*;
(
	input logic clk,
	input logic [SW-1:0] raddr,
	input wr_t wr,
	output logic [SW-1:0] rnx,
	output logic [SW-1:0] rpv,
	output logic [DATA_WIDTH-1:0] rval
);
	logic [SW-1:0] nx_mem [CAPACITY];
	logic [SW-1:0] pv_mem [CAPACITY];
	logic [DATA_WIDTH-1:0] val_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.nx_we) nx_mem[wr.addr] <= wr.nx;
		if (wr.pv_we) pv_mem[wr.addr] <= wr.pv;
		if (wr.val_we) val_mem[wr.addr] <= wr.val;
		rnx <= nx_mem[raddr];
		rpv <= pv_mem[raddr];
		rval <= val_mem[raddr];
	end
endmodule

@@ hw/rtl/adll_free.sv @@
// ---------------------------------------------------------------------------
// adll_free
// stack of free slots with in-use flags
// ---------------------------------------------------------------------------
module adll_free
	import adll_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic pop,
	input logic push,
	input logic clr,
	input logic [SW-1:0] push_slot,
	input logic [SW-1:0] chk_slot,
	output logic [SW-1:0] top_slot,
	output logic empty,
	output logic chk_used
);
	logic [SW-1:0] stk_q [CAPACITY];
	logic [CAPACITY-1:0] used_q;
	logic [CW-1:0] top_q;

	assign empty = (top_q == '0);
	assign top_slot = stk_q[SW'(top_q - CW'(1))];
	assign chk_used = used_q[chk_slot];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= CW'(CAPACITY);
			used_q <= '0;
			for (int i = 0; i < CAPACITY; i++) stk_q[i] <= SW'(CAPACITY - 1 - i);
		end else if (clr) begin
			top_q <= CW'(CAPACITY);
			used_q <= '0;
			for (int i = 0; i < CAPACITY; i++) stk_q[i] <= SW'(CAPACITY - 1 - i);
		end else if (pop) begin
			top_q <= top_q - CW'(1);
			used_q[top_slot] <= 1'b1;
		end else if (push) begin
			stk_q[SW'(top_q)] <= push_slot;
			top_q <= top_q + CW'(1);
			used_q[push_slot] <= 1'b0;
		end
	end
endmodule

@@ hw/rtl/array_doubly_linked_list.sv @@
// ---------------------------------------------------------------------------
// array_doubly_linked_list
// fixed-capacity doubly linked list in slot memory with a free slot stack
// ---------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                          tuser
// s_axis   in   slot[3:0] list_position[8:4] value[40:9]    kind[3:0]
// m_axis   out  read_value[31:0] result_slot[35:32]         -
//               status[37:36] element_count[42:38]
// one operation at a time, in steps: accept, slot memory read, hand-off
// inserts and deletes also write up to two neighbour links, in S_PNX, S_SPV
// read by position walks one link per S_WALK step, at most CAPACITY/2 - 1
// reset clears control state and refills the free stack at once
// a held result stalls the hand-off of the next operation, not its processing
// ---------------------------------------------------------------------------
module array_doubly_linked_list
	import adll_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [47:0] s_axis_tdata, // slot, list_position, value
	input logic [3:0] s_axis_tuser, // kind
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [47:0] m_axis_tdata // read_value, result_slot, status, element_count
);
	state_t st_q, st_d;
	logic [3:0] kind_q;
	logic [SW-1:0] slot_q, cur_q, head_q, tail_q;
	logic [CW-1:0] cnt_q, steps_q;
	logic dir_q;
	logic [1:0] pre_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [SW-1:0] p_q, s_q, pnx_q, spv_q;
	logic sok_q;
	logic [31:0] res_rv_q, rv_q;
	logic [SW-1:0] res_rs_q, rs_q;
	logic [1:0] res_st_q, stat_q;
	logic [CW-1:0] ec_q;
	logic ov_q;

	logic [SW-1:0] raddr, rnx, rpv, top_slot;
	logic [DATA_WIDTH-1:0] rval;
	wr_t wr;
	logic pop, push, clr, fempty, used;

	wire [3:0] i_kind = s_axis_tuser;
	wire [SW-1:0] i_slot = s_axis_tdata[3:0];
	wire [CW-1:0] i_pos = s_axis_tdata[8:4];
	wire acc = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (st_q == S_IDLE);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {5'd0, ec_q, stat_q, rs_q, rv_q};

	adll_mem u_mem (.clk, .raddr, .wr, .rnx, .rpv, .rval);
	adll_free u_free (.clk, .arst_n, .pop, .push, .clr, .push_slot(slot_q),
		.chk_slot(slot_q), .top_slot, .empty(fempty), .chk_used(used));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else st_q <= st_d;
	end

	// start of a read: slot, direction and links to walk
	logic [SW-1:0] a_start;
	logic [CW-1:0] a_steps, half;
	logic a_dir;
	logic [1:0] a_st;

	assign half = (cnt_q - CW'(1)) >> 1;

	always_comb begin
		a_start = i_slot; a_steps = '0; a_dir = 1'b0; a_st = ST_OK;
		if (i_kind == K_HEAD) a_start = head_q;
		else if (i_kind == K_TAIL) a_start = tail_q;
		else if (i_kind == K_READ_POS) begin
			if (i_pos >= cnt_q) a_st = ST_RANGE;
			else if (i_pos <= half) begin
				a_start = head_q; a_steps = i_pos;
			end else begin
				a_start = tail_q; a_steps = cnt_q - CW'(1) - i_pos; a_dir = 1'b1;
			end
		end
		if ((i_kind == K_HEAD || i_kind == K_TAIL || i_kind == K_READ_POS) && cnt_q == '0)
			a_st = ST_EMPTY;
	end

	logic [SW-1:0] n_p, n_s, n_pnx, n_spv;
	logic n_pok, n_sok, n_ins, n_del, res_ld, rd_op, walk, emit;
	logic [31:0] d_rv;
	logic [SW-1:0] d_rs;
	logic [1:0] d_st;

	always_comb begin
		st_d = st_q;
		raddr = cur_q;
		wr = '0;
		pop = 1'b0; push = 1'b0; clr = 1'b0;
		n_p = rpv; n_s = rnx; n_pnx = top_slot; n_spv = top_slot;
		n_pok = 1'b0; n_sok = 1'b0; n_ins = 1'b0; n_del = 1'b0;
		res_ld = 1'b0; rd_op = 1'b0; walk = 1'b0; emit = 1'b0;
		d_rv = '0; d_rs = '0; d_st = ST_OK;
		unique case (st_q)
			S_IDLE: begin
				raddr = a_start;
				if (acc) st_d = S_RD;
			end
			S_RD: begin
				res_ld = 1'b1;
				st_d = S_DONE;
				unique case (kind_q)
					K_PUSH_HEAD: begin
						n_s = head_q; n_sok = (cnt_q != '0);
						if (fempty) d_st = ST_FULL;
						else n_ins = 1'b1;
					end
					K_PUSH_TAIL: begin
						n_p = tail_q; n_pok = (cnt_q != '0);
						if (fempty) d_st = ST_FULL;
						else n_ins = 1'b1;
					end
					K_INS_AFTER: begin
						n_p = slot_q; n_pok = 1'b1; n_s = rnx; n_sok = (slot_q != tail_q);
						if (!used) d_st = ST_RANGE;
						else if (fempty) d_st = ST_FULL;
						else n_ins = 1'b1;
					end
					K_INS_BEFORE: begin
						n_s = slot_q; n_sok = 1'b1; n_p = rpv; n_pok = (slot_q != head_q);
						if (!used) d_st = ST_RANGE;
						else if (fempty) d_st = ST_FULL;
						else n_ins = 1'b1;
					end
					K_DELETE: begin
						n_pok = (slot_q != head_q) && (slot_q != tail_q); n_sok = n_pok;
						n_pnx = rnx; n_spv = rpv;
						if (cnt_q == '0) d_st = ST_EMPTY;
						else if (!used) d_st = ST_RANGE;
						else n_del = 1'b1;
					end
					K_READ_POS, K_HEAD, K_TAIL: rd_op = 1'b1;
					K_NEXT: begin
						if (!used || slot_q == tail_q) d_st = ST_RANGE;
						else d_rs = rnx;
					end
					K_PREV: begin
						if (!used || slot_q == head_q) d_st = ST_RANGE;
						else d_rs = rpv;
					end
					K_CLEAR: clr = 1'b1;
					default: ;
				endcase
				if (n_ins) begin
					pop = 1'b1; d_rs = top_slot;
					wr.val_we = 1'b1; wr.nx_we = 1'b1; wr.pv_we = 1'b1;
					wr.addr = top_slot; wr.val = val_q; wr.nx = n_s; wr.pv = n_p;
				end
				if (n_del) push = 1'b1;
				if ((n_ins || n_del) && n_pok) st_d = S_PNX;
				else if ((n_ins || n_del) && n_sok) st_d = S_SPV;
			end
			S_WALK: rd_op = 1'b1;
			S_PNX: begin
				wr.nx_we = 1'b1; wr.addr = p_q; wr.nx = pnx_q;
				st_d = sok_q ? S_SPV : S_DONE;
			end
			S_SPV: begin
				wr.pv_we = 1'b1; wr.addr = s_q; wr.pv = spv_q;
				st_d = S_DONE;
			end
			S_DONE: begin
				if (!ov_q || m_axis_tready) begin
					emit = 1'b1; st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
		if (rd_op) begin
			res_ld = 1'b1; st_d = S_DONE;
			if (pre_q != ST_OK) d_st = pre_q;
			else if (steps_q == '0) begin
				d_rs = cur_q; d_rv = 32'(rval);
			end else begin
				res_ld = 1'b0; walk = 1'b1;
				raddr = dir_q ? rpv : rnx; st_d = S_WALK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0; head_q <= '0; tail_q <= '0; cnt_q <= '0;
		end else begin
			if (emit) ov_q <= 1'b1;
			else if (m_axis_tready) ov_q <= 1'b0;
			if (n_ins) begin
				cnt_q <= cnt_q + CW'(1);
				if (!n_pok) head_q <= top_slot;
				if (!n_sok) tail_q <= top_slot;
			end else if (n_del) begin
				cnt_q <= cnt_q - CW'(1);
				if (slot_q == head_q && slot_q == tail_q) begin
					head_q <= '0; tail_q <= '0;
				end else if (slot_q == head_q) head_q <= rnx;
				else if (slot_q == tail_q) tail_q <= rpv;
			end else if (clr) begin
				cnt_q <= '0; head_q <= '0; tail_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q <= i_kind; slot_q <= i_slot;
			val_q <= s_axis_tdata[DATA_WIDTH+8:9];
			cur_q <= a_start; steps_q <= a_steps; dir_q <= a_dir; pre_q <= a_st;
		end else if (walk) begin
			cur_q <= raddr; steps_q <= steps_q - CW'(1);
		end
		if (n_ins || n_del) begin
			p_q <= n_p; s_q <= n_s; pnx_q <= n_pnx; spv_q <= n_spv; sok_q <= n_sok;
		end
		if (res_ld) begin
			res_rv_q <= d_rv; res_rs_q <= d_rs; res_st_q <= d_st;
		end
		if (emit) begin
			rv_q <= res_rv_q; rs_q <= res_rs_q; stat_q <= res_st_q; ec_q <= cnt_q;
		end
	end
endmodule

@@ verif/array_doubly_linked_list_tb.sv @@
// ---------------------------------------------------------------------------
// array_doubly_linked_list_tb
// drives list operations over the stream ports and checks every transfer
// against a behavioural list with its own slot arrays and free stack
// ---------------------------------------------------------------------------
module array_doubly_linked_list_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import adll_pkg::*;

	typedef struct packed {
		logic [4:0] n_elem;
		logic [1:0] status;
		logic [3:0] rd_slot;
		logic [31:0] rd_value;
	} list_result_t;

	class list_scoreboard;
		logic [31:0] slot_val [16];
		logic [3:0] nxt [16];
		logic [3:0] prv [16];
		logic [3:0] free_stk [16];
		bit listed [16];
		int free_top;
		logic [3:0] head;
		logic [3:0] tail;
		int n;
		list_result_t expected_q[$];
		int errors;
		int checked;

		function void empty_list();
			for (int i = 0; i < 16; i++) begin
				listed[i] = 0;
				free_stk[i] = 4'(15 - i);
			end
			free_top = 16;
			head = 0;
			tail = 0;
			n = 0;
		endfunction

		function logic [3:0] take(logic [31:0] v);
			logic [3:0] s;
			free_top--;
			s = free_stk[free_top];
			slot_val[s] = v;
			listed[s] = 1;
			n++;
			return s;
		endfunction

		function logic [3:0] add_head(logic [31:0] v);
			bit was_empty;
			logic [3:0] s;
			was_empty = (n == 0);
			s = take(v);
			if (was_empty) begin
				tail = s;
			end else begin
				nxt[s] = head;
				prv[head] = s;
			end
			head = s;
			return s;
		endfunction

		function logic [3:0] add_tail(logic [31:0] v);
			bit was_empty;
			logic [3:0] s;
			was_empty = (n == 0);
			s = take(v);
			if (was_empty) begin
				head = s;
			end else begin
				nxt[tail] = s;
				prv[s] = tail;
			end
			tail = s;
			return s;
		endfunction

		function bit is_listed(logic [3:0] s);
			return listed[s];
		endfunction

		function void note_operation(kind_t k, logic [3:0] s, logic [4:0] p, logic [31:0] v);
			list_result_t r;
			logic [3:0] cur;
			logic [3:0] l;
			r = '0;
			case (k)
				K_PUSH_HEAD, K_PUSH_TAIL: begin
					if (free_top == 0) r.status = ST_FULL;
					else r.rd_slot = (k == K_PUSH_HEAD) ? add_head(v) : add_tail(v);
				end
				K_INS_AFTER, K_INS_BEFORE: begin
					if (!listed[s]) r.status = ST_RANGE;
					else if (free_top == 0) r.status = ST_FULL;
					else if (k == K_INS_AFTER && s == tail) r.rd_slot = add_tail(v);
					else if (k == K_INS_BEFORE && s == head) r.rd_slot = add_head(v);
					else if (k == K_INS_AFTER) begin
						l = nxt[s];
						cur = take(v);
						nxt[cur] = l;
						prv[l] = cur;
						nxt[s] = cur;
						prv[cur] = s;
						r.rd_slot = cur;
					end else begin
						l = prv[s];
						cur = take(v);
						nxt[l] = cur;
						prv[cur] = l;
						nxt[cur] = s;
						prv[s] = cur;
						r.rd_slot = cur;
					end
				end
				K_DELETE: begin
					if (n == 0) r.status = ST_EMPTY;
					else if (!listed[s]) r.status = ST_RANGE;
					else begin
						if (s == head && s == tail) begin
							head = 0;
							tail = 0;
						end else if (s == head) begin
							head = nxt[s];
						end else if (s == tail) begin
							tail = prv[s];
						end else begin
							nxt[prv[s]] = nxt[s];
							prv[nxt[s]] = prv[s];
						end
						listed[s] = 0;
						if (free_top < 16) begin
							free_stk[free_top] = s;
							free_top++;
						end
						n--;
					end
				end
				K_READ_POS: begin
					if (n == 0) r.status = ST_EMPTY;
					else if (p >= n) r.status = ST_RANGE;
					else begin
						if (p <= (n - 1) / 2) begin
							cur = head;
							for (int i = 0; i < p; i++) cur = nxt[cur];
						end else begin
							cur = tail;
							for (int i = 0; i < n - 1 - p; i++) cur = prv[cur];
						end
						r.rd_slot = cur;
						r.rd_value = slot_val[cur];
					end
				end
				K_HEAD, K_TAIL: begin
					if (n == 0) r.status = ST_EMPTY;
					else begin
						r.rd_slot = (k == K_HEAD) ? head : tail;
						r.rd_value = slot_val[r.rd_slot];
					end
				end
				K_NEXT: begin
					if (!listed[s] || s == tail) r.status = ST_RANGE;
					else r.rd_slot = nxt[s];
				end
				K_PREV: begin
					if (!listed[s] || s == head) r.status = ST_RANGE;
					else r.rd_slot = prv[s];
				end
				K_CLEAR: empty_list();
				default: ;
			endcase
			r.n_elem = 5'(n);
			expected_q.push_back(r);
		endfunction

		function void check_result(list_result_t got);
			list_result_t e;
			checked++;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result transfer", 64'(0), 64'(got));
				return;
			end
			e = expected_q.pop_front();
			if (got.rd_value !== e.rd_value)
				report_mismatch("read_value", 64'(e.rd_value), 64'(got.rd_value));
			if (got.rd_slot !== e.rd_slot)
				report_mismatch("result_slot", 64'(e.rd_slot), 64'(got.rd_slot));
			if (got.status !== e.status)
				report_mismatch("status", 64'(e.status), 64'(got.status));
			if (got.n_elem !== e.n_elem)
				report_mismatch("element_count", 64'(e.n_elem), 64'(got.n_elem));
		endfunction

		function void report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
			errors++;
			if (errors <= 50) $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [3:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata;

	list_scoreboard list_sb;
	bit calm;
	bit hold_off;
	int ops_sent;

	array_doubly_linked_list i_dut (.*);

	initial clk = 0;
	always #5 clk = ~clk;

	task automatic send_op(logic [3:0] k, logic [3:0] s, logic [4:0] p, logic [31:0] v);
		while (!calm && $urandom_range(99) < 15) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= k;
		s_axis_tdata <= {7'd0, v, p, s};
		do @(posedge clk); while (!s_axis_tready);
		list_sb.note_operation(kind_t'(k), s, p, v);
		ops_sent++;
		@(negedge clk);
	endtask

	function automatic logic [3:0] pick_slot();
		logic [3:0] s;
		for (int t = 0; t < 8; t++) begin
			s = 4'($urandom_range(15));
			if (list_sb.is_listed(s)) return s;
		end
		return 4'($urandom_range(15));
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_op();
		int r;
		r = $urandom_range(99);
		if (r < 12) send_op(K_PUSH_HEAD, 4'($urandom), 5'($urandom), rand_value());
		else if (r < 24) send_op(K_PUSH_TAIL, 4'($urandom), 5'($urandom), rand_value());
		else if (r < 34) send_op(K_INS_AFTER, pick_slot(), 5'($urandom), rand_value());
		else if (r < 44) send_op(K_INS_BEFORE, pick_slot(), 5'($urandom), rand_value());
		else if (r < 58) send_op(K_DELETE, pick_slot(), 5'($urandom), $urandom);
		else if (r < 72) send_op(K_READ_POS, 4'($urandom), 5'($urandom_range(17)), $urandom);
		else if (r < 77) send_op(K_HEAD, 4'($urandom), 5'($urandom), $urandom);
		else if (r < 82) send_op(K_TAIL, 4'($urandom), 5'($urandom), $urandom);
		else if (r < 89) send_op(K_NEXT, pick_slot(), 5'($urandom), $urandom);
		else if (r < 96) send_op(K_PREV, pick_slot(), 5'($urandom), $urandom);
		else if (r < 98) send_op(K_CLEAR, 4'($urandom), 5'($urandom), $urandom);
		else send_op(4'($urandom_range(15, 11)), 4'($urandom), 5'($urandom), $urandom);
	endtask

	// result side: random stalls, plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) m_axis_tready <= 0;
		else m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 15);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) list_sb.check_result(m_axis_tdata[42:0]);
	end

	initial begin
		#2ms;
		$display("array_doubly_linked_list verification failed");
		$finish;
	end

	initial begin
		int wait_cycles;
		list_sb = new();
		list_sb.empty_list();
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 0;
		calm = 0;
		hold_off = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty cases, fill to full, edges of every field
		send_op(K_DELETE, 0, 0, 0);
		send_op(K_READ_POS, 0, 0, 0);
		send_op(K_HEAD, 0, 0, 0);
		send_op(K_TAIL, 0, 0, 0);
		send_op(K_NEXT, 4'hf, 5'h1f, 0);
		send_op(K_INS_AFTER, 3, 0, 32'h1234);
		send_op(K_PUSH_HEAD, 4'hf, 5'h1f, 32'h8000_0000);
		send_op(K_PUSH_TAIL, 0, 0, 32'h7fff_ffff);
		send_op(K_INS_AFTER, 1, 0, 32'hffff_ffff);
		send_op(K_INS_BEFORE, 0, 0, 32'h5555_aaaa);
		send_op(K_INS_AFTER, 0, 0, 32'haaaa_5555);
		send_op(K_INS_BEFORE, 1, 0, 32'h0);
		send_op(K_NEXT, 1, 0, 0);
		send_op(K_PREV, 3, 0, 0);
		send_op(K_PREV, 0, 0, 0);
		send_op(K_READ_POS, 0, 5'd4, 0);
		send_op(K_READ_POS, 0, 5'd16, 0);
		send_op(K_DELETE, 0, 0, 0);
		send_op(K_DELETE, 1, 0, 0);
		send_op(4'd13, 4'hf, 5'h1f, 32'hffff_ffff);
		for (int i = 0; i < 13; i++) send_op(K_PUSH_TAIL, 0, 0, $urandom);
		send_op(K_PUSH_HEAD, 0, 0, 1);
		send_op(K_INS_AFTER, 2, 0, 2);
		send_op(K_READ_POS, 0, 5'd15, 0);
		send_op(K_READ_POS, 0, 5'd9, 0);
		send_op(K_CLEAR, 0, 0, 0);

		// long hold-off on the result side while operations keep coming
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 20; i++) random_op();
		join

		for (int i = 0; i < 600; i++) begin
			calm = (i >= 250 && i < 350);
			random_op();
		end
		calm = 0;
		s_axis_tvalid <= 0;

		wait_cycles = 0;
		while (list_sb.expected_q.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (40) @(posedge clk);
		if (list_sb.expected_q.size() != 0)
			list_sb.report_mismatch("results outstanding", 64'(list_sb.expected_q.size()), 64'(0));
		$display("%0d operations sent, %0d results checked", ops_sent, list_sb.checked);
		$display("covered pushes, inserts, deletes, walks, link reads, clear, full and empty lists");
		if (list_sb.errors == 0) begin
			$display("array_doubly_linked_list verification clean");
		end else begin
			$display("array_doubly_linked_list verification failed");
		end
		$finish;
	end
endmodule
